FILE: rtl/core/ssff_pkg.sv
// Shared constants, register map and level/character helpers for the shade fade filter.
// Self-contained; used by shade_stencil_fade_filter.
`default_nettype none

package ssff_pkg;

	localparam int unsigned MAX_WIDTH_DEF = 128;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;
	localparam int unsigned ROW_W  = 12;
	localparam int unsigned COL_W  = 7;

	localparam logic [7:0]  FRAME_WIDTH_RST  = 8'd100;
	localparam logic [12:0] FRAME_HEIGHT_RST = 13'd20;
	localparam logic [3:0]  MIN_LEVEL_RST    = 4'd0;
	localparam logic [12:0] MAX_HEIGHT       = 13'd4096;

	localparam logic [3:0] RAMP_TOP   = 4'd9;
	localparam logic [7:0] BLANK_CHAR = 8'h20;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_MIN_LEVEL    = 2'd2
	} reg_idx_t;

	// Position of a byte in the ramp " .:-=+*#%@"; anything else is level 0.
	function automatic logic [3:0] level_of(input logic [7:0] c);
		logic [3:0] lv;
		case (c)
			8'h2E:   lv = 4'd1; // .
			8'h3A:   lv = 4'd2; // :
			8'h2D:   lv = 4'd3; // -
			8'h3D:   lv = 4'd4; // =
			8'h2B:   lv = 4'd5; // +
			8'h2A:   lv = 4'd6; // *
			8'h23:   lv = 4'd7; // #
			8'h25:   lv = 4'd8; // %
			8'h40:   lv = 4'd9; // @
			default: lv = 4'd0;
		endcase
		return lv;
	endfunction

	function automatic logic [7:0] ramp_char(input logic [3:0] lv);
		logic [7:0] c;
		case (lv)
			4'd1:    c = 8'h2E;
			4'd2:    c = 8'h3A;
			4'd3:    c = 8'h2D;
			4'd4:    c = 8'h3D;
			4'd5:    c = 8'h2B;
			4'd6:    c = 8'h2A;
			4'd7:    c = 8'h23;
			4'd8:    c = 8'h25;
			4'd9:    c = 8'h40;
			default: c = BLANK_CHAR;
		endcase
		return c;
	endfunction

	// Truncating divide by 7 for sums up to 63: multiply by 37/256.
	function automatic logic [3:0] div7(input logic [5:0] s);
		logic [11:0] p;
		p = 12'(s) * 12'd37;
		return p[11:8];
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/shade_stencil_fade_filter.sv
// Five-point fade filter over a raster stream of shade characters.
// Depends on ssff_pkg for the register map, reset values and ramp helpers.
//
// Usage:
//   Pixels enter on pix_valid/pix_stall, one character per beat, raster order, row 0 first.
//   Results leave on res_valid/res_stall with shade_char, column, row and last_of_run.
//   A pixel at row r gives the result for (column, r-1); pixels on the last row also
//   give their own blank pixel as a second beat. Pixels on row 0 give nothing unless
//   row 0 is the last row.
//   Path: an accepted pixel is held in the working stage; its result beats are loaded
//   from there into the output register. Throughput: one pixel per cycle while the
//   output is not stalled; a last-row pixel past row 0 holds the stage for both its beats.
//   The rate is set by the single output register draining one beat a cycle and by
//   the line-buffer RAMs, written once and read at two addresses per cycle.
//   Stall: the output register holds its beat while res_stall is high; a pixel in the
//   working stage with a beat to give then waits and pix_stall rises in the same cycle.
//   Reset: counters return to column 0 / row 0, registers take their defaults
//   (width 100, height 20, floor 0). The line buffers are not cleared; they are
//   filled by the first two rows of a frame, so no clearing pass is needed.
//   Configuration goes through the APB port at byte addresses 0, 4, 8; the user must write
//   it only while the block is idle, which the block itself does not enforce.
`default_nettype none

module shade_stencil_fade_filter #(
	parameter int unsigned MAX_WIDTH = ssff_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ssff_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [ssff_pkg::DATA_W-1:0]   pwdata,
	output logic      [ssff_pkg::DATA_W-1:0]   prdata,
	output logic                               pready,

	input  wire logic                          pix_valid,
	output logic                               pix_stall,
	input  wire logic [7:0]                    pixel_char,

	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic [7:0]                         shade_char,
	output logic [ssff_pkg::COL_W-1:0]         column,
	output logic [ssff_pkg::ROW_W-1:0]         row,
	output logic                               last_of_run
);

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned CNTW = $clog2(MAX_WIDTH + 1);
	localparam int unsigned WVW  = (CNTW > 8) ? CNTW : 8;
	localparam int unsigned XW   = (CW > ssff_pkg::COL_W) ? CW : ssff_pkg::COL_W;
	localparam int unsigned RW   = ssff_pkg::ROW_W;

	// configuration
	logic [7:0]  frame_width_q;
	logic [12:0] frame_height_q;
	logic [3:0]  min_level_q;
	logic        cfg_wr;
	ssff_pkg::reg_idx_t reg_idx;

	// raster position of the next pixel
	logic [CW-1:0] col_cnt_q;
	logic [RW-1:0] row_cnt_q;

	// line buffers of levels
	logic [3:0] above_mem_q     [MAX_WIDTH];
	logic [3:0] two_above_mem_q [MAX_WIDTH];

	// working stage
	logic          s1_valid_q;
	logic          s1_second_q;
	logic [CW-1:0] x_s1;
	logic [RW-1:0] r_s1;
	logic [3:0]    down_s1;
	logic [3:0]    centre_s1;
	logic [3:0]    up_s1;
	logic [3:0]    right_s1;
	logic          emit_up_s1;
	logic          interior_s1;
	logic          last_row_s1;
	logic [3:0]    left_q;

	// output register
	logic                     res_valid_q;
	logic [7:0]               shade_char_q;
	logic [ssff_pkg::COL_W-1:0] column_q;
	logic [RW-1:0]            row_q;
	logic                     last_of_run_q;

	// accept-side geometry
	logic [WVW-1:0] eff_w;
	logic [WVW-1:0] fw_ext;
	logic [WVW-1:0] x_p1;
	logic [12:0]    eff_h;
	logic [12:0]    r_p1;
	logic           row_end;
	logic           last_row;
	logic           interior;
	logic [CW-1:0]  rd_x;
	logic [CW-1:0]  rd_r;
	logic           byp_x;
	logic           byp_r;

	// handshake and beat control
	logic pix_acc;
	logic first_beat;
	logic has_beat;
	logic beat_last;
	logic out_free;
	logic beat_load;
	logic s1_adv;

	// level arithmetic
	logic [5:0]    sum;
	logic [3:0]    lv_raw;
	logic [3:0]    lv_clip;
	logic [3:0]    floor_lv;
	logic [3:0]    lv;
	logic [XW-1:0] x_ext;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign reg_idx = ssff_pkg::reg_idx_t'(paddr[3:2]);

	always_comb begin
		case (reg_idx)
			ssff_pkg::REG_FRAME_WIDTH:  prdata = ssff_pkg::DATA_W'(frame_width_q);
			ssff_pkg::REG_FRAME_HEIGHT: prdata = ssff_pkg::DATA_W'(frame_height_q);
			ssff_pkg::REG_MIN_LEVEL:    prdata = ssff_pkg::DATA_W'(min_level_q);
			default:                    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= ssff_pkg::FRAME_WIDTH_RST;
			frame_height_q <= ssff_pkg::FRAME_HEIGHT_RST;
			min_level_q    <= ssff_pkg::MIN_LEVEL_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				ssff_pkg::REG_FRAME_WIDTH:  frame_width_q  <= pwdata[7:0];
				ssff_pkg::REG_FRAME_HEIGHT: frame_height_q <= pwdata[12:0];
				ssff_pkg::REG_MIN_LEVEL:    min_level_q    <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// geometry of the next pixel, with out-of-range settings clamped
	always_comb begin
		fw_ext = WVW'(frame_width_q);
		if (fw_ext == '0)
			eff_w = WVW'(1);
		else if (fw_ext > WVW'(MAX_WIDTH))
			eff_w = WVW'(MAX_WIDTH);
		else
			eff_w = fw_ext;

		if (frame_height_q == '0)
			eff_h = 13'd1;
		else if (frame_height_q > ssff_pkg::MAX_HEIGHT)
			eff_h = ssff_pkg::MAX_HEIGHT;
		else
			eff_h = frame_height_q;

		x_p1     = WVW'(col_cnt_q) + WVW'(1);
		r_p1     = 13'(row_cnt_q) + 13'd1;
		row_end  = (x_p1 >= eff_w);
		last_row = (r_p1 >= eff_h);
		interior = (col_cnt_q != '0) && (x_p1 < eff_w) && (row_cnt_q >= RW'(2))
			&& (r_p1 <= eff_h);

		rd_x = col_cnt_q;
		rd_r = (col_cnt_q == CW'(MAX_WIDTH - 1)) ? '0 : col_cnt_q + CW'(1);
	end

	// beat sequencing out of the working stage
	always_comb begin
		pix_acc    = pix_valid & ~pix_stall;
		first_beat = emit_up_s1 & ~s1_second_q;
		has_beat   = s1_valid_q & (first_beat | last_row_s1);
		beat_last  = ~first_beat | ~last_row_s1;
		out_free   = ~res_valid_q | ~res_stall;
		beat_load  = has_beat & out_free;
		s1_adv     = s1_valid_q & (~has_beat | (out_free & beat_last));
		pix_stall  = s1_valid_q & ~s1_adv;
		// forward the stage's line-buffer write when it lands on an address that is being read
		byp_x      = s1_adv & (x_s1 == rd_x);
		byp_r      = s1_adv & (x_s1 == rd_r);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (pix_acc) begin
			if (row_end) begin
				col_cnt_q <= '0;
				row_cnt_q <= last_row ? '0 : row_cnt_q + RW'(1);
			end else begin
				col_cnt_q <= col_cnt_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s1_second_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (pix_acc)
				s1_valid_q <= 1'b1;
			else if (s1_adv)
				s1_valid_q <= 1'b0;

			if (pix_acc || s1_adv)
				s1_second_q <= 1'b0;
			else if (beat_load && !beat_last)
				s1_second_q <= 1'b1;

			if (beat_load)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	// line buffers: written as the stage retires, read as a pixel enters
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			above_mem_q[x_s1]     <= down_s1;
			two_above_mem_q[x_s1] <= centre_s1;
			left_q                <= centre_s1;
		end
		if (pix_acc) begin
			x_s1        <= col_cnt_q;
			r_s1        <= row_cnt_q;
			down_s1     <= ssff_pkg::level_of(pixel_char);
			emit_up_s1  <= (row_cnt_q != '0);
			interior_s1 <= interior;
			last_row_s1 <= last_row;
			centre_s1   <= byp_x ? down_s1 : above_mem_q[rd_x];
			right_s1    <= byp_r ? down_s1 : above_mem_q[rd_r];
			up_s1       <= byp_x ? centre_s1 : two_above_mem_q[rd_x];
		end
	end

	always_comb begin
		sum      = 6'(centre_s1) * 6'd3 + 6'(up_s1) + 6'(down_s1) + 6'(left_q)
			+ 6'(right_s1);
		lv_raw   = ssff_pkg::div7(sum);
		lv_clip  = (lv_raw > ssff_pkg::RAMP_TOP) ? ssff_pkg::RAMP_TOP : lv_raw;
		floor_lv = (min_level_q > ssff_pkg::RAMP_TOP) ? ssff_pkg::RAMP_TOP : min_level_q;
		lv       = (lv_clip <= floor_lv) ? floor_lv : lv_clip;
		x_ext    = XW'(x_s1);
	end

	always_ff @(posedge clk) begin
		if (beat_load) begin
			if (first_beat && interior_s1)
				shade_char_q <= ssff_pkg::ramp_char(lv);
			else
				shade_char_q <= ssff_pkg::BLANK_CHAR;
			column_q      <= x_ext[ssff_pkg::COL_W-1:0];
			row_q         <= first_beat ? r_s1 - RW'(1) : r_s1;
			last_of_run_q <= beat_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign shade_char  = shade_char_q;
	assign column      = column_q;
	assign row         = row_q;
	assign last_of_run = last_of_run_q;

endmodule

`default_nettype wire
